[rtl/core/bli_pkg.sv]
// Package for the bounded list block: request and response word types
// and operation codes. No dependencies.
package bli_pkg;

	// Operation codes carried in the op field of a request word
	localparam logic [3:0] OP_INS_FRONT  = 4'd0;
	localparam logic [3:0] OP_INS_REAR   = 4'd1;
	localparam logic [3:0] OP_INS_AT     = 4'd2;
	localparam logic [3:0] OP_INS_SORTED = 4'd3;
	localparam logic [3:0] OP_DEL_FRONT  = 4'd4;
	localparam logic [3:0] OP_DEL_REAR   = 4'd5;
	localparam logic [3:0] OP_DEL_FIRST  = 4'd6;
	localparam logic [3:0] OP_DEL_ALL    = 4'd7;
	localparam logic [3:0] OP_READ       = 4'd8;

	// Word width of a list entry
	localparam int WORD_W = 32;

	typedef struct packed {
		logic [3:0]               op;
		logic signed [WORD_W-1:0] item;
		logic [4:0]               pos;
	} req_word_t;

	typedef struct packed {
		logic                     ok;
		logic [4:0]               removed;
		logic [4:0]               fill;
		logic signed [WORD_W-1:0] entry;
	} rsp_word_t;

endpackage

[rtl/core/bounded_list_insert_delete.sv]
// Bounded packed list of signed 32-bit words with a fill count; the entries live in one
// bli_ram and a sequencer shifts them with one read and at most one write per cycle. One request
// word is worked at a time. An insert moves k entries up, where k is at most the fill count;
// delete front, first or all run a compaction scan over every entry; delete rear, failed
// operations and unknown codes go straight to the response, and a read waits on the RAM read.
// Each waits in S_FIN until the response slot is free. The shift and scan
// loops are bound by the single RAM read port, one entry per cycle. A new request is taken
// while the previous response word still waits in the output register. No clearing pass.
// Depends on bli_pkg and bli_ram.
module bounded_list_insert_delete #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  bli_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output bli_pkg::rsp_word_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 5) ? CW : 5;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SHUP = 5'b00010,
		S_SCAN = 5'b00100,
		S_RDWT = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                           state_q;
	logic [CW-1:0]                    fill_q;
	logic [CW-1:0]                    cur_q;
	logic [CW-1:0]                    wr_q;
	logic [CW-1:0]                    tgt_q;
	logic [CW-1:0]                    removed_q;
	logic [3:0]                       mode_q;
	logic signed [bli_pkg::WORD_W-1:0] item_q;
	logic signed [bli_pkg::WORD_W-1:0] entry_q;
	logic                             found_q;
	logic                             ok_q;
	logic                             rsp_valid_q;
	bli_pkg::rsp_word_t               rsp_q;

	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [bli_pkg::WORD_W-1:0]       ram_wdata;
	logic [AW-1:0]                    ram_raddr;
	logic [bli_pkg::WORD_W-1:0]       ram_rdata;

	logic [XW-1:0]                    fill_x;
	logic [XW-1:0]                    pos_x;
	logic                             room;
	logic                             accept;
	logic [CW-1:0]                    ins_tgt;
	logic                             go_on;
	logic                             hit;
	logic                             last;
	logic                             rsp_free;

	bli_ram #(
		.WIDTH(bli_pkg::WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign fill_x    = XW'(fill_q);
	assign pos_x     = XW'(req.pos);
	assign room      = fill_q < CW'(DEPTH);
	assign req_stall = state_q != S_IDLE;
	assign accept    = req_valid && (state_q == S_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Pick the gap position for a positional insert
	always_comb begin
		case (req.op)
			bli_pkg::OP_INS_FRONT: ins_tgt = '0;
			bli_pkg::OP_INS_AT:    ins_tgt = (pos_x < fill_x) ? pos_x[CW-1:0] : fill_q;
			default:               ins_tgt = fill_q;
		endcase
	end

	// Decide whether the shift goes on and whether the scanned word is dropped
	always_comb begin
		if (mode_q == bli_pkg::OP_INS_SORTED) begin
			go_on = (cur_q != '0) && ($signed(ram_rdata) > item_q);
		end else begin
			go_on = cur_q > tgt_q;
		end
		case (mode_q)
			bli_pkg::OP_DEL_FRONT: hit = cur_q == '0;
			bli_pkg::OP_DEL_FIRST: hit = (ram_rdata == item_q) && !found_q;
			default:               hit = ram_rdata == item_q;
		endcase
		last = (cur_q + CW'(1)) == fill_q;
	end

	// Drive the RAM ports: reads run one entry ahead of writes
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (req.op == bli_pkg::OP_READ) begin
					ram_raddr = pos_x[AW-1:0];
				end else if (req.op <= bli_pkg::OP_INS_SORTED) begin
					ram_raddr = AW'(fill_q - CW'(1));
				end
			end
			S_SHUP: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(cur_q);
				ram_wdata = go_on ? ram_rdata : item_q;
				ram_raddr = AW'(cur_q - CW'(2));
			end
			S_SCAN: begin
				ram_we    = !hit;
				ram_waddr = AW'(wr_q);
				ram_raddr = AW'(cur_q + CW'(1));
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequence one request word through shift, scan or read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			cur_q     <= '0;
			wr_q      <= '0;
			tgt_q     <= '0;
			removed_q <= '0;
			mode_q    <= '0;
			item_q    <= '0;
			entry_q   <= '0;
			found_q   <= 1'b0;
			ok_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q    <= req.op;
						item_q    <= req.item;
						removed_q <= '0;
						found_q   <= 1'b0;
						ok_q      <= 1'b0;
						entry_q   <= '0;
						cur_q     <= '0;
						wr_q      <= '0;
						state_q   <= S_FIN;
						case (req.op)
							bli_pkg::OP_INS_FRONT, bli_pkg::OP_INS_REAR,
							bli_pkg::OP_INS_AT, bli_pkg::OP_INS_SORTED: begin
								if (room) begin
									cur_q   <= fill_q;
									tgt_q   <= ins_tgt;
									state_q <= S_SHUP;
								end
							end
							bli_pkg::OP_DEL_REAR: begin
								if (fill_q != '0) begin
									fill_q    <= fill_q - CW'(1);
									removed_q <= CW'(1);
									ok_q      <= 1'b1;
								end
							end
							bli_pkg::OP_DEL_FRONT, bli_pkg::OP_DEL_FIRST,
							bli_pkg::OP_DEL_ALL: begin
								if (fill_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							bli_pkg::OP_READ: begin
								if (pos_x < fill_x) begin
									state_q <= S_RDWT;
								end
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SHUP: begin
					if (go_on) begin
						cur_q <= cur_q - CW'(1);
					end else begin
						fill_q  <= fill_q + CW'(1);
						ok_q    <= 1'b1;
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						removed_q <= removed_q + CW'(1);
						found_q   <= 1'b1;
					end else begin
						wr_q <= wr_q + CW'(1);
					end
					cur_q <= cur_q + CW'(1);
					if (last) begin
						fill_q  <= wr_q + CW'(!hit);
						ok_q    <= (removed_q != '0) || hit;
						state_q <= S_FIN;
					end
				end
				S_RDWT: begin
					entry_q <= ram_rdata;
					ok_q    <= 1'b1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Load the response word when the slot frees, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (state_q == S_FIN && rsp_free) begin
				rsp_valid_q   <= 1'b1;
				rsp_q.ok      <= ok_q;
				rsp_q.removed <= 5'(removed_q);
				rsp_q.fill    <= 5'(fill_q);
				rsp_q.entry   <= entry_q;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/bli_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[tb/sv/bli_checker.sv]
// Checker for the bounded list block: watches the request and response channels,
// predicts each response word and compares it field by field. Depends on bli_pkg.
module bli_checker
	import bli_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_word_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_word_t rsp,
	output int        fail_count,
	output int        pending
);

	// Shadow copy of the list
	logic signed [WORD_W-1:0] list_mem [DEPTH];
	int                       list_fill;

	// Response words still owed by the block, oldest first
	rsp_word_t owed_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	// Open a gap at index p and store v there
	function automatic void open_gap(int p, logic signed [WORD_W-1:0] v);
		for (int k = list_fill; k > p; k--)
			list_mem[k] = list_mem[k-1];
		list_mem[p] = v;
		list_fill++;
	endfunction

	// Close the gap at index p
	function automatic void close_gap(int p);
		for (int k = p; k + 1 < list_fill; k++)
			list_mem[k] = list_mem[k+1];
		list_fill--;
	endfunction

	// Apply one request word to the shadow list and return the response word
	function automatic rsp_word_t list_apply(req_word_t r);
		rsp_word_t o;
		int        k;
		o = '0;
		case (r.op)
			OP_INS_FRONT: if (list_fill < DEPTH) begin
				open_gap(0, r.item);
				o.ok = 1'b1;
			end
			OP_INS_REAR: if (list_fill < DEPTH) begin
				open_gap(list_fill, r.item);
				o.ok = 1'b1;
			end
			OP_INS_AT: if (list_fill < DEPTH) begin
				open_gap((r.pos < list_fill) ? int'(r.pos) : list_fill, r.item);
				o.ok = 1'b1;
			end
			OP_INS_SORTED: if (list_fill < DEPTH) begin
				// shift larger entries up, scanning down from the rear
				k = list_fill;
				while (k > 0 && list_mem[k-1] > r.item) begin
					list_mem[k] = list_mem[k-1];
					k--;
				end
				list_mem[k] = r.item;
				list_fill++;
				o.ok = 1'b1;
			end
			OP_DEL_FRONT: if (list_fill > 0) begin
				close_gap(0);
				o.ok      = 1'b1;
				o.removed = 5'd1;
			end
			OP_DEL_REAR: if (list_fill > 0) begin
				list_fill--;
				o.ok      = 1'b1;
				o.removed = 5'd1;
			end
			OP_DEL_FIRST: begin
				for (k = 0; k < list_fill; k++) begin
					if (list_mem[k] == r.item) begin
						close_gap(k);
						o.ok      = 1'b1;
						o.removed = 5'd1;
						break;
					end
				end
			end
			OP_DEL_ALL: begin
				k = 0;
				while (k < list_fill) begin
					if (list_mem[k] == r.item) begin
						close_gap(k);
						o.removed++;
					end else begin
						k++;
					end
				end
				o.ok = (o.removed != 5'd0);
			end
			OP_READ: if (r.pos < list_fill) begin
				o.entry = list_mem[r.pos];
				o.ok    = 1'b1;
			end
			default: ;
		endcase
		o.fill = 5'(list_fill);
		return o;
	endfunction

	// Report one field that differs
	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("rsp field %s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare accepted responses, then predict accepted requests
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			foreach (list_mem[k])
				list_mem[k] = '0;
			list_fill = 0;
			owed_q.delete();
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_q.size() == 0) begin
					$error("rsp word with none expected: %p", rsp);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					check_field("ok", want.ok, rsp.ok);
					check_field("removed", want.removed, rsp.removed);
					check_field("fill", want.fill, rsp.fill);
					check_field("entry", want.entry, rsp.entry);
				end
			end
			if (req_valid && !req_stall)
				owed_q.push_back(list_apply(req));
			pending = owed_q.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// Top of the bounded list testbench: clock, reset, request stimulus and
// response back-pressure. Depends on bli_pkg, bli_checker and the block.
module tb;
	import bli_pkg::*;

	localparam int DEPTH = 16;
	localparam int RAND_WORDS = 1730;
	localparam int HOLD_AT = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int PAUSE_AT = 1000;
	localparam int CALM_FROM = 1200;
	localparam int CALM_TO = 1450;
	localparam logic [3:0] OP_BAD_LOW = 4'd9;
	localparam logic [3:0] OP_BAD_TOP = 4'd15;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	// Phases of the random part
	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_SORTED = 2;
	localparam int MODE_MIXED = 3;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;
	int        fail_count;
	int        pending;

	int sent;
	bit calm;
	bit hold_go;

	bounded_list_insert_delete #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	bli_checker #(.DEPTH(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock, period 8
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bound the run
	initial begin
		#4000000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic req_word_t mk(logic [3:0] op, logic signed [WORD_W-1:0] item,
			logic [4:0] pos);
		req_word_t w;
		w.op   = op;
		w.item = item;
		w.pos  = pos;
		return w;
	endfunction

	// Favor a small pool of values so that matches and duplicates are common
	function automatic logic signed [WORD_W-1:0] pick_item();
		int sel;
		sel = $urandom_range(0, 11);
		if (sel <= 6)
			return $signed(32'(sel)) - 32'sd3;
		else if (sel == 7)
			return WORD_MIN;
		else if (sel == 8)
			return WORD_MAX;
		else
			return $signed(32'($urandom));
	endfunction

	function automatic logic [4:0] pick_pos();
		if ($urandom_range(0, 1) == 0)
			return 5'($urandom_range(0, 31));
		else
			return 5'($urandom_range(0, DEPTH));
	endfunction

	// Offer one word at the falling edge, idle first at random, wait for acceptance
	task automatic send_word(req_word_t w);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < 20) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	// Response back-pressure: random stalls, one long hold-off
	initial begin
		int  hold_left;
		bit  hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !calm && ($urandom_range(0, 99) < 20);
			end
		end
	end

	// Reset, directed words, random phases, drain and verdict
	initial begin
		int          mode;
		int          phase_len;
		int          sel;
		logic [3:0]  op;
		req_word_t   w;
		bit          paused;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_stall = 1'b0;
		sent      = 0;
		calm      = 1'b0;
		hold_go   = 1'b0;
		paused    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list: every delete and read fails, unknown codes change nothing
		send_word(mk(OP_DEL_FRONT, 32'sd0, 5'd0));
		send_word(mk(OP_DEL_REAR, 32'sd0, 5'd0));
		send_word(mk(OP_DEL_FIRST, 32'sd0, 5'd0));
		send_word(mk(OP_DEL_ALL, 32'sd0, 5'd0));
		send_word(mk(OP_READ, 32'sd0, 5'd0));
		send_word(mk(OP_BAD_TOP, WORD_MAX, 5'd31));
		// front, rear and positional inserts, extreme values, position past the fill count
		send_word(mk(OP_INS_FRONT, WORD_MIN, 5'd0));
		send_word(mk(OP_INS_REAR, WORD_MAX, 5'd0));
		send_word(mk(OP_INS_AT, 32'sd0, 5'd31));
		send_word(mk(OP_INS_AT, -32'sd1, 5'd1));
		// sorted insert into an unordered list
		send_word(mk(OP_INS_SORTED, 32'sd5, 5'd0));
		send_word(mk(OP_READ, 32'sd0, 5'd0));
		send_word(mk(OP_READ, 32'sd0, 5'd4));
		send_word(mk(OP_READ, 32'sd0, 5'd5));
		send_word(mk(OP_INS_REAR, 32'sd0, 5'd0));
		send_word(mk(OP_DEL_FIRST, 32'sd0, 5'd0));
		send_word(mk(OP_DEL_ALL, 32'sd7, 5'd0));
		send_word(mk(OP_INS_FRONT, 32'sd0, 5'd0));
		send_word(mk(OP_DEL_ALL, 32'sd0, 5'd0));
		send_word(mk(OP_DEL_FIRST, 32'sd12345, 5'd0));
		send_word(mk(OP_READ, 32'sd0, 5'd16));
		send_word(mk(OP_BAD_LOW, 32'sd1, 5'd2));
		send_word(mk(OP_DEL_REAR, 32'sd0, 5'd0));
		send_word(mk(OP_DEL_FRONT, 32'sd0, 5'd0));

		// random phases
		while (sent < RAND_WORDS) begin
			mode      = $urandom_range(MODE_FILL, MODE_MIXED);
			phase_len = $urandom_range(20, 60);
			// empty the list first so that sorted inserts see an ordered list
			if (mode == MODE_SORTED)
				repeat (DEPTH + 1) send_word(mk(OP_DEL_REAR, pick_item(), pick_pos()));
			repeat (phase_len) begin
				sel = $urandom_range(0, 99);
				case (mode)
					MODE_FILL:
						op = (sel < 80) ? 4'($urandom_range(OP_INS_FRONT, OP_INS_SORTED))
							: 4'($urandom_range(OP_DEL_FRONT, OP_READ));
					MODE_DRAIN:
						op = (sel < 80) ? 4'($urandom_range(OP_DEL_FRONT, OP_DEL_ALL))
							: 4'($urandom_range(OP_INS_FRONT, OP_READ));
					MODE_SORTED:
						if (sel < 60)
							op = OP_INS_SORTED;
						else if (sel < 75)
							op = OP_READ;
						else if (sel < 90)
							op = (sel < 83) ? OP_DEL_FIRST : OP_DEL_ALL;
						else
							op = (sel < 95) ? OP_DEL_FRONT : OP_DEL_REAR;
					default:
						op = (sel < 90) ? 4'($urandom_range(OP_INS_FRONT, OP_READ))
							: 4'($urandom_range(OP_BAD_LOW, OP_BAD_TOP));
				endcase
				w = mk(op, pick_item(), pick_pos());
				// hold off the receiver once, pause once until all words are back
				if (sent >= HOLD_AT)
					hold_go = 1'b1;
				if (sent >= PAUSE_AT && !paused) begin
					paused = 1'b1;
					@(negedge clk);
					req_valid <= 1'b0;
					wait (pending == 0);
				end
				calm = (sent >= CALM_FROM && sent < CALM_TO);
				send_word(w);
			end
		end
		calm = 1'b0;
		@(negedge clk);
		req_valid <= 1'b0;

		// drain, then let the block settle
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
